// ===== rtl/cbb_pkg.sv =====
// Shared constants, codes and control types of the circular byte buffer.
`default_nettype none
package cbb_pkg;
	localparam int MAX_CAPACITY = 16384;
	localparam int MAX_BURST    = 64;
	localparam int ADDR_W       = $clog2(MAX_CAPACITY);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int LEN_W        = $clog2(MAX_BURST) + 1;
	localparam int RD_W         = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
	localparam int BYTE_W       = 8;
	localparam int CMD_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET  = 2'd0,
		CMD_WSTART = 2'd1,
		CMD_WBYTE  = 2'd2,
		CMD_READ   = 2'd3
	} command_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} ctrl_state_t;

	typedef struct packed {
		logic step;
		logic rd_issue;
		logic load_result;
		logic load_byte;
	} dp_ctrl_t;

	typedef struct packed {
		logic             rd_go;
		logic             rd_more;
		logic [CNT_W-1:0] cap;
	} dp_status_t;

	function automatic logic [CNT_W-1:0] capacity_of(input logic [CNT_W-1:0] req);
		logic [CNT_W-1:0] lim;
		logic [CNT_W-1:0] c;
		lim = (req > CNT_W'(MAX_CAPACITY)) ? CNT_W'(MAX_CAPACITY) : req;
		c = CNT_W'(1);
		for (int i = 0; i < CNT_W; i++) begin
			if (lim[i]) begin
				c = CNT_W'(1) << i;
			end
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/cbb_ifs.sv =====
// Handshake interfaces for the request and response words.
`default_nettype none
interface cbb_req_if;
	logic                       valid;
	logic                       ready;
	logic [cbb_pkg::CMD_W-1:0]  command;
	logic [cbb_pkg::LEN_W-1:0]  length;
	logic [cbb_pkg::BYTE_W-1:0] data_in;
	modport source (output valid, command, length, data_in, input ready);
	modport sink (input valid, command, length, data_in, output ready);
endinterface

interface cbb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [cbb_pkg::BYTE_W-1:0] data_out;
	logic                       data_valid;
	logic                       last;
	logic [cbb_pkg::CNT_W-1:0]  fill_count;
	modport source (output valid, ok, data_out, data_valid, last, fill_count, input ready);
	modport sink (input valid, ok, data_out, data_valid, last, fill_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbb_ctrl.sv =====
// Controller: handshakes, read streaming sequencer and response valid.
`default_nettype none
module cbb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic                rsp_ready,
	output logic                     rsp_valid,
	input  wire cbb_pkg::dp_status_t st,
	output cbb_pkg::dp_ctrl_t        ctl
);
	import cbb_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_result || ctl.load_byte) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				if (req_valid && out_free) begin
					ctl.step = 1'b1;
					if (st.rd_go) begin
						ctl.rd_issue = 1'b1;
						state_d      = ST_READ;
					end else begin
						ctl.load_result = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					ctl.load_byte = 1'b1;
					if (st.rd_more) begin
						ctl.rd_issue = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/cbb_dp.sv =====
// Datapath: byte store, pointers, fill count, burst tracking and response word.
`default_nettype none
module cbb_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cbb_pkg::CNT_W-1:0]    requested_capacity,
	input  wire logic [cbb_pkg::CMD_W-1:0]    command,
	input  wire logic [cbb_pkg::LEN_W-1:0]    length,
	input  wire logic [cbb_pkg::BYTE_W-1:0]   data_in,
	input  wire cbb_pkg::dp_ctrl_t            ctl,
	output cbb_pkg::dp_status_t               st,
	output logic                              ok,
	output logic [cbb_pkg::BYTE_W-1:0]        data_out,
	output logic                              data_valid,
	output logic                              last,
	output logic [cbb_pkg::CNT_W-1:0]         fill_count
);
	import cbb_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_CAPACITY];
	logic [BYTE_W-1:0] rdata_q;

	logic [CNT_W-1:0]  cap_q;
	logic [ADDR_W-1:0] mask_q;
	logic [ADDR_W-1:0] wp_q, rp_q, wofs_q;
	logic [CNT_W-1:0]  stored_q, stored_d;
	logic [LEN_W-1:0]  brem_q, blen_q;
	logic              bdisc_q;
	logic [RD_W-1:0]   rd_left_q;

	logic [CNT_W-1:0]  cap_new;
	logic              len_ok, admit, read_ok, ok_d;
	logic              burst_open, wr_en, commit;
	logic [ADDR_W-1:0] wofs_inc;

	assign cap_new    = capacity_of(requested_capacity);
	assign len_ok     = length <= LEN_W'(MAX_BURST);
	assign admit      = len_ok && ((cap_q - stored_q) >= CNT_W'(length));
	assign read_ok    = len_ok && (CNT_W'(length) <= stored_q);
	assign burst_open = brem_q != '0;
	assign wr_en      = ctl.step && command == CMD_WBYTE && burst_open && !bdisc_q;
	assign commit     = wr_en && brem_q == LEN_W'(1);
	assign wofs_inc   = (wofs_q + ADDR_W'(1)) & mask_q;

	assign st.rd_go   = command == CMD_READ && read_ok && length != '0;
	assign st.rd_more = rd_left_q != '0;
	assign st.cap     = cap_q;

	always_comb begin
		stored_d = stored_q;
		ok_d     = 1'b0;
		case (command)
			CMD_RESET: begin
				stored_d = '0;
				ok_d     = 1'b1;
			end
			CMD_WSTART: begin
				ok_d = admit;
			end
			CMD_WBYTE: begin
				ok_d = burst_open && !bdisc_q;
				if (commit) begin
					stored_d = stored_q + CNT_W'(blen_q);
				end
			end
			CMD_READ: begin
				ok_d = read_ok;
				if (st.rd_go) begin
					stored_d = stored_q - CNT_W'(length);
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CNT_W'(MAX_CAPACITY);
			mask_q    <= ADDR_W'(MAX_CAPACITY - 1);
			wp_q      <= '0;
			rp_q      <= '0;
			wofs_q    <= '0;
			stored_q  <= '0;
			brem_q    <= '0;
			blen_q    <= '0;
			bdisc_q   <= 1'b0;
			rd_left_q <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_new;
			mask_q   <= ADDR_W'(cap_new - CNT_W'(1));
			wp_q     <= '0;
			rp_q     <= '0;
			stored_q <= '0;
			brem_q   <= '0;
			blen_q   <= '0;
			bdisc_q  <= 1'b0;
		end else begin
			if (ctl.step) begin
				stored_q <= stored_d;
				case (command)
					CMD_RESET: begin
						wp_q    <= '0;
						rp_q    <= '0;
						brem_q  <= '0;
						blen_q  <= '0;
						bdisc_q <= 1'b0;
					end
					CMD_WSTART: begin
						blen_q  <= length;
						brem_q  <= length;
						bdisc_q <= !admit;
						wofs_q  <= wp_q;
					end
					CMD_WBYTE: begin
						if (burst_open) begin
							brem_q <= brem_q - LEN_W'(1);
						end
						if (wr_en) begin
							wofs_q <= wofs_inc;
						end
						if (commit) begin
							wp_q <= wofs_inc;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.rd_issue) begin
				rp_q <= (rp_q + ADDR_W'(1)) & mask_q;
				if (ctl.step) begin
					rd_left_q <= RD_W'(length - LEN_W'(1));
				end else begin
					rd_left_q <= rd_left_q - RD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wofs_q] <= data_in;
		end
		if (ctl.rd_issue) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			ok         <= ok_d;
			data_out   <= '0;
			data_valid <= 1'b0;
			last       <= 1'b1;
			fill_count <= stored_d;
		end else if (ctl.load_byte) begin
			ok         <= 1'b1;
			data_out   <= rdata_q;
			data_valid <= 1'b1;
			last       <= !st.rd_more;
			fill_count <= stored_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/circular_byte_buffer.sv =====
// Circular byte buffer with all-or-nothing burst writes and reads.
// Every item other than an accepted non-empty read gives one response word,
// registered in the cycle after the item is taken; a new item is taken in the
// cycle its predecessor's word is delivered. While responses are taken, items
// are taken at one per cycle and an accepted read of n bytes gives n words at
// one byte per cycle, each passing the store's read register into the response
// word, paced by its single read port; no new item is taken until the last byte
// is loaded. Capacity is the largest power of two not above the configured
// value (at most 16384, at least 1); a configuration write also empties the
// buffer. The byte store is not cleared after reset and needs no initialization.
`default_nettype none
module circular_byte_buffer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [cbb_pkg::CNT_W-1:0] requested_capacity,
	cbb_req_if.sink                        req,
	cbb_rsp_if.source                      rsp
);
	import cbb_pkg::*;

	dp_ctrl_t   ctl;
	dp_status_t st;

	cbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.st        (st),
		.ctl       (ctl)
	);

	cbb_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.requested_capacity (requested_capacity),
		.command            (req.command),
		.length             (req.length),
		.data_in            (req.data_in),
		.ctl                (ctl),
		.st                 (st),
		.ok                 (rsp.ok),
		.data_out           (rsp.data_out),
		.data_valid         (rsp.data_valid),
		.last               (rsp.last),
		.fill_count         (rsp.fill_count)
	);

`ifndef NO_ASSERTIONS
	a_stream_holds_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data_valid && !rsp.last |-> !req.ready)
		else $error("request taken in the middle of a read stream");
	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.fill_count <= st.cap)
		else $error("fill count above capacity");
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data_valid |-> rsp.ok)
		else $error("read byte without ok");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data_valid |-> rsp.last && rsp.data_out == '0)
		else $error("non-data word not marked last");
`endif
endmodule
`default_nettype wire

// ===== tb/circular_byte_buffer_tb.sv =====
// Self-checking testbench for circular_byte_buffer: burst writes, reads, refusals and wrap.
`timescale 1ns / 100ps
module circular_byte_buffer_tb;
	import cbb_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		command_t          cmd;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
	} req_word_t;

	typedef struct {
		logic              ok;
		logic [BYTE_W-1:0] data;
		logic              data_valid;
		logic              last;
		logic [CNT_W-1:0]  fill;
	} rsp_word_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_capacity;

	cbb_req_if req_ch ();
	cbb_rsp_if rsp_ch ();

	circular_byte_buffer dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.requested_capacity (cfg_capacity),
		.req                (req_ch),
		.rsp                (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	req_word_t request_words[$];
	rsp_word_t expected_words[$];

	int errors = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit req_taken = 1'b0;

	// shadow of the buffer
	logic [BYTE_W-1:0] shadow_bytes [MAX_CAPACITY];
	int sh_req_cap = MAX_CAPACITY;
	int sh_wr_ptr = 0;
	int sh_rd_ptr = 0;
	int sh_fill = 0;
	int sh_burst_left = 0;
	int sh_burst_len = 0;
	bit sh_burst_drop = 1'b0;

	// stimulus-side fill tracking, to aim reads
	int gen_cap = MAX_CAPACITY;
	int gen_fill = 0;

	function automatic int rounded_capacity(input int req);
		int lim;
		int c;
		lim = (req > MAX_CAPACITY) ? MAX_CAPACITY : req;
		c = 1;
		while (c * 2 <= lim)
			c = c * 2;
		return c;
	endfunction

	function automatic void clear_shadow();
		sh_wr_ptr = 0;
		sh_rd_ptr = 0;
		sh_fill = 0;
		sh_burst_left = 0;
		sh_burst_len = 0;
		sh_burst_drop = 1'b0;
	endfunction

	function automatic void expect_word(input logic ok, input logic [BYTE_W-1:0] data,
			input logic dv, input logic last);
		rsp_word_t r;
		r.ok = ok;
		r.data = data;
		r.data_valid = dv;
		r.last = last;
		r.fill = CNT_W'(sh_fill);
		expected_words.push_back(r);
	endfunction

	function automatic void predict_buffer(input req_word_t w);
		int cap;
		int mask;
		int idx;
		int n;
		bit admit;
		bit ok;
		logic [BYTE_W-1:0] b;
		cap = rounded_capacity(sh_req_cap);
		mask = cap - 1;
		n = int'(w.len);
		case (w.cmd)
			CMD_RESET: begin
				clear_shadow();
				expect_word(1'b1, '0, 1'b0, 1'b1);
			end
			CMD_WSTART: begin
				admit = (n <= MAX_BURST) && (cap - sh_fill >= n);
				sh_burst_len = n;
				sh_burst_left = n;
				sh_burst_drop = !admit;
				expect_word(admit, '0, 1'b0, 1'b1);
			end
			CMD_WBYTE: begin
				ok = 1'b0;
				if (sh_burst_left != 0) begin
					if (!sh_burst_drop) begin
						idx = (sh_wr_ptr + sh_burst_len - sh_burst_left) & mask;
						shadow_bytes[idx] = w.data;
						ok = 1'b1;
					end
					sh_burst_left--;
					if (sh_burst_left == 0 && !sh_burst_drop) begin
						sh_wr_ptr = (sh_wr_ptr + sh_burst_len) & mask;
						sh_fill += sh_burst_len;
					end
				end
				expect_word(ok, '0, 1'b0, 1'b1);
			end
			default: begin
				if (n > MAX_BURST || n > sh_fill) begin
					expect_word(1'b0, '0, 1'b0, 1'b1);
				end else if (n == 0) begin
					expect_word(1'b1, '0, 1'b0, 1'b1);
				end else begin
					sh_fill -= n;
					for (int i = 0; i < n; i++) begin
						b = shadow_bytes[sh_rd_ptr];
						sh_rd_ptr = (sh_rd_ptr + 1) & mask;
						expect_word(1'b1, b, 1'b1, i == n - 1);
					end
				end
			end
		endcase
	endfunction

	// monitor: check responses, track config writes, predict accepted requests
	always @(posedge clk) begin
		rsp_word_t e;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			req_taken = 1'b0;
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) begin
					if (expected_words.size() == 0) begin
						$error("unexpected word: ok=%0d data_out=%0h fill_count=%0d",
							rsp_ch.ok, rsp_ch.data_out, rsp_ch.fill_count);
						errors++;
					end else begin
						e = expected_words.pop_front();
						if (rsp_ch.ok !== e.ok) begin
							$error("ok: expected %0d, got %0d", e.ok, rsp_ch.ok);
							errors++;
						end
						if (rsp_ch.data_out !== e.data) begin
							$error("data_out: expected %0h, got %0h", e.data, rsp_ch.data_out);
							errors++;
						end
						if (rsp_ch.data_valid !== e.data_valid) begin
							$error("data_valid: expected %0d, got %0d", e.data_valid,
								rsp_ch.data_valid);
							errors++;
						end
						if (rsp_ch.last !== e.last) begin
							$error("last: expected %0d, got %0d", e.last, rsp_ch.last);
							errors++;
						end
						if (rsp_ch.fill_count !== e.fill) begin
							$error("fill_count: expected %0d, got %0d", e.fill,
								rsp_ch.fill_count);
							errors++;
						end
					end
				end
				if (cfg_we) begin
					sh_req_cap = int'(cfg_capacity);
					clear_shadow();
				end
				if (req_ch.valid && req_ch.ready) begin
					predict_buffer('{command_t'(req_ch.command), req_ch.length, req_ch.data_in});
					req_taken = 1'b1;
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		req_word_t w;
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (request_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = request_words.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.command <= w.cmd;
				req_ch.length <= w.len;
				req_ch.data_in <= w.data;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response ready, with one long hold-off when requested
	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				rdy = ($urandom_range(0, 99) >= stall_pct);
			end
			rsp_ch.ready <= rdy;
		end
	end

	function automatic void push_word(input command_t cmd, input int len,
			input logic [BYTE_W-1:0] data);
		req_word_t w;
		w.cmd = cmd;
		w.len = LEN_W'(len);
		w.data = data;
		request_words.push_back(w);
	endfunction

	function automatic void add_random(input int n);
		int added;
		int pick;
		int len;
		int nb;
		int rl;
		int k;
		bit admit;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_BURST)
					: $urandom_range(1, 8);
				if (len > n - added)
					len = n - added;
				admit = (gen_cap - gen_fill >= len);
				nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
				push_word(CMD_WSTART, len, BYTE_W'($urandom));
				added++;
				for (int i = 0; i < nb; i++) begin
					if (i == nb / 2 && $urandom_range(0, 7) == 0) begin
						rl = $urandom_range(0, gen_fill < 16 ? gen_fill : 16);
						push_word(CMD_READ, rl, BYTE_W'($urandom));
						gen_fill -= rl;
						added++;
					end
					push_word(CMD_WBYTE, $urandom_range(0, 127), BYTE_W'($urandom));
					added++;
				end
				if (nb < len) begin
					push_word(CMD_WSTART, 0, BYTE_W'($urandom));
					added++;
				end else if (admit) begin
					gen_fill += len;
				end
			end else if (pick < 80) begin
				rl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
					: $urandom_range(0, gen_fill < 16 ? gen_fill : 16);
				if ($urandom_range(0, 9) == 0 && gen_fill >= 17)
					rl = $urandom_range(17, gen_fill < MAX_BURST ? gen_fill : MAX_BURST);
				push_word(CMD_READ, rl, BYTE_W'($urandom));
				if (rl <= MAX_BURST && rl <= gen_fill)
					gen_fill -= rl;
				added++;
			end else if (pick < 88) begin
				// stray byte, no burst open
				push_word(CMD_WBYTE, $urandom_range(0, 127), BYTE_W'($urandom));
				added++;
			end else if (pick < 92) begin
				push_word(CMD_RESET, $urandom_range(0, 127), BYTE_W'($urandom));
				gen_fill = 0;
				added++;
			end else begin
				// oversize burst, bytes discarded, then closed
				push_word(CMD_WSTART, $urandom_range(MAX_BURST + 1, 127), BYTE_W'($urandom));
				k = $urandom_range(0, 3);
				for (int i = 0; i < k; i++)
					push_word(CMD_WBYTE, $urandom_range(0, 127), BYTE_W'($urandom));
				push_word(CMD_WSTART, 0, BYTE_W'($urandom));
				added += k + 2;
			end
		end
	endfunction

	task automatic wait_idle();
		while (request_words.size() != 0 || req_ch.valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_capacity <= CNT_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_cap = rounded_capacity(v);
		gen_fill = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_capacity = CNT_W'(MAX_CAPACITY);
		req_ch.valid = 1'b0;
		req_ch.command = CMD_RESET;
		req_ch.length = '0;
		req_ch.data_in = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, default capacity
		push_word(CMD_RESET, 0, 8'h00);
		push_word(CMD_WSTART, 0, 8'h00);
		push_word(CMD_READ, 0, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h5A);
		push_word(CMD_READ, 1, 8'h00);
		push_word(CMD_WSTART, 127, 8'hFF);
		push_word(CMD_WBYTE, 127, 8'hFF);
		push_word(CMD_WSTART, MAX_BURST + 1, 8'h00);
		push_word(CMD_WSTART, 3, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h00);
		push_word(CMD_WBYTE, 0, 8'hFF);
		push_word(CMD_READ, 1, 8'h00);
		push_word(CMD_WBYTE, 0, 8'hA5);
		push_word(CMD_READ, 4, 8'h00);
		push_word(CMD_READ, 127, 8'h00);
		push_word(CMD_WSTART, 2, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h81);
		push_word(CMD_READ, 2, 8'h00);
		push_word(CMD_WSTART, 1, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h7E);
		push_word(CMD_READ, 2, 8'h00);
		push_word(CMD_WSTART, 2, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h11);
		push_word(CMD_RESET, 0, 8'h00);
		push_word(CMD_WBYTE, 0, 8'h22);
		push_word(CMD_READ, 1, 8'h00);
		wait_idle();

		// capacity 64: fill completely, refuse, drain
		write_capacity(100);
		send_idle_pct = 59;
		push_word(CMD_WSTART, MAX_BURST, 8'h00);
		for (int i = 0; i < MAX_BURST; i++)
			push_word(CMD_WBYTE, 0, BYTE_W'($urandom));
		push_word(CMD_WSTART, 1, 8'h00);
		push_word(CMD_READ, MAX_BURST + 1, 8'h00);
		push_word(CMD_READ, MAX_BURST, 8'h00);
		add_random(5);
		wait_idle();

		write_capacity(2);
		send_idle_pct = 0;
		stall_pct = 59;
		add_random(6);
		wait_idle();

		write_capacity(0);
		send_idle_pct = 21;
		stall_pct = 21;
		add_random(6);
		wait_idle();

		// receiver holds off while the sender keeps offering
		write_capacity(32767);
		send_idle_pct = 0;
		stall_pct = 0;
		add_random(8);
		hold_token++;
		wait_idle();

		write_capacity(MAX_CAPACITY);
		send_idle_pct = 21;
		stall_pct = 21;
		add_random(5);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d words never arrived", expected_words.size());
			errors++;
		end
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/cbb_pkg.sv
rtl/cbb_ifs.sv
rtl/cbb_ctrl.sv
rtl/cbb_dp.sv
rtl/circular_byte_buffer.sv
tb/circular_byte_buffer_tb.sv
